>>> rtl/cvcc_pkg.sv
// shared constants, register codes and types for the cv/cc dual pid regulator
package cvcc_pkg;

  localparam int DRIVE_MAX = 4096;
  localparam int INTEG_W   = 32;
  localparam int SAMPLE_W  = 12;
  localparam int GAIN_W    = 12;
  localparam int FRAC_W    = 8;
  localparam int ERR_W     = SAMPLE_W + 1;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int DRIVE_W   = $clog2(DRIVE_MAX + 1);
  localparam int P_W       = GAIN_W + 1 + ERR_W;
  localparam int I_W       = GAIN_W + 1 + INTEG_W;
  localparam int D_W       = GAIN_W + 1 + DIFF_W;
  localparam int SUM_W     = I_W + 2;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLT_LIMIT = 3'd0,
    REG_CURR_LIMIT = 3'd1,
    REG_KP_VOLT    = 3'd2,
    REG_KI_VOLT    = 3'd3,
    REG_KD_VOLT    = 3'd4,
    REG_KP_CURR    = 3'd5,
    REG_KI_CURR    = 3'd6,
    REG_KD_CURR    = 3'd7
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0] KP_VOLT_RST = GAIN_W'(256);
  localparam logic [GAIN_W-1:0] KI_VOLT_RST = GAIN_W'(51);
  localparam logic [GAIN_W-1:0] KD_VOLT_RST = GAIN_W'(51);
  localparam logic [GAIN_W-1:0] KP_CURR_RST = GAIN_W'(128);
  localparam logic [GAIN_W-1:0] KI_CURR_RST = GAIN_W'(26);
  localparam logic [GAIN_W-1:0] KD_CURR_RST = GAIN_W'(51);

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] volt_limit;
    logic [SAMPLE_W-1:0] curr_limit;
    gains_t              volt;
    gains_t              curr;
  } cfg_t;

endpackage

>>> rtl/cv_cc_dual_pid_regulator_core.sv
// top level of the cv/cc dual pid regulator: sample register, loop state, result register
//
// One item (a voltage and a current sample) is taken per clock while sample_stall is low.
// The item sits in the sample register while the selected loop computes error, integrator
// update and the three-term sum, and the drive is then held in the result register until
// taken. Sustained rate is one item per cycle while result_stall does not hold the result;
// the limit is the feedback from each drive into the integrator gate of the next item, which
// closes while that item is in the sample register. The voltage loop runs when the voltage
// sample is above the voltage limit register, otherwise the current loop runs; loop_mode
// reports which one. Configuration writes are always accepted (cfg_ready is held high) and
// should be issued only while no item is in flight.
module cv_cc_dual_pid_regulator_core
  import cvcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic [SAMPLE_W-1:0]  volt_sample,
  input  logic [SAMPLE_W-1:0]  curr_sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [DRIVE_W-1:0]   drive,
  output logic                 loop_mode,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  cfg_t cfg;

  logic                      sample_full;
  logic [SAMPLE_W-1:0]       volt_q;
  logic [SAMPLE_W-1:0]       curr_q;
  logic                      take;
  logic                      advance;

  logic signed [ERR_W-1:0]   prev_err_volt;
  logic signed [ERR_W-1:0]   prev_err_curr;
  logic signed [INTEG_W-1:0] integ_volt;
  logic signed [INTEG_W-1:0] integ_curr;
  logic [DRIVE_W-1:0]        last_drive;

  logic                      sel_volt;
  logic                      integ_en;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   prev_err;
  logic signed [INTEG_W-1:0] integ;
  gains_t                    gains;
  logic signed [INTEG_W-1:0] integ_next;
  logic [DRIVE_W-1:0]        drive_next;

  assign cfg_ready = 1'b1;

  cvcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake
  assign advance      = sample_full && (!result_valid || !result_stall);
  assign sample_stall = sample_full && !advance;
  assign take         = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_full <= 1'b0;
    end else if (take) begin
      sample_full <= 1'b1;
    end else if (advance) begin
      sample_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      volt_q <= volt_sample;
      curr_q <= curr_sample;
    end
  end

  // loop select
  assign sel_volt = volt_q > cfg.volt_limit;
  assign err = sel_volt ? $signed(ERR_W'(cfg.volt_limit) - ERR_W'(volt_q))
                        : $signed(ERR_W'(cfg.curr_limit) - ERR_W'(curr_q));
  assign prev_err = sel_volt ? prev_err_volt : prev_err_curr;
  assign integ    = sel_volt ? integ_volt : integ_curr;
  assign gains    = sel_volt ? cfg.volt : cfg.curr;
  assign integ_en = (last_drive > DRIVE_W'(1)) && (last_drive < DRIVE_W'(DRIVE_MAX));

  cvcc_pid_calc u_pid (
    .err        (err),
    .prev_err   (prev_err),
    .integ      (integ),
    .integ_en   (integ_en),
    .gains      (gains),
    .integ_next (integ_next),
    .drive_next (drive_next)
  );

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err_volt <= '0;
      prev_err_curr <= '0;
      integ_volt    <= '0;
      integ_curr    <= '0;
      last_drive    <= '0;
    end else if (advance) begin
      last_drive <= drive_next;
      if (sel_volt) begin
        prev_err_volt <= err;
        integ_volt    <= integ_next;
      end else begin
        prev_err_curr <= err;
        integ_curr    <= integ_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive     <= drive_next;
      loop_mode <= sel_volt;
    end
  end

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (drive <= DRIVE_W'(DRIVE_MAX)))
    else $error("drive above limit");

  a_last_drive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last_drive == drive))
    else $error("last drive differs from result");

  a_curr_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && sel_volt) |=> (integ_curr == $past(integ_curr)
                               && prev_err_curr == $past(prev_err_curr)))
    else $error("current loop state moved while voltage loop ran");

  a_volt_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && !sel_volt) |=> (integ_volt == $past(integ_volt)
                                && prev_err_volt == $past(prev_err_volt)))
    else $error("voltage loop state moved while current loop ran");

  a_integ_gate: assert property (@(posedge clk) disable iff (rst)
    (advance && !integ_en) |=> (integ_volt == $past(integ_volt)
                                && integ_curr == $past(integ_curr)))
    else $error("integrator moved with gate closed");

endmodule

>>> rtl/cvcc_cfg_regs.sv
// configuration register file: limits and loop gains
module cvcc_cfg_regs
  import cvcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volt_limit <= '0;
      cfg.curr_limit <= '0;
      cfg.volt.kp    <= KP_VOLT_RST;
      cfg.volt.ki    <= KI_VOLT_RST;
      cfg.volt.kd    <= KD_VOLT_RST;
      cfg.curr.kp    <= KP_CURR_RST;
      cfg.curr.ki    <= KI_CURR_RST;
      cfg.curr.kd    <= KD_CURR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VOLT_LIMIT: cfg.volt_limit <= SAMPLE_W'(cfg_data);
        REG_CURR_LIMIT: cfg.curr_limit <= SAMPLE_W'(cfg_data);
        REG_KP_VOLT:    cfg.volt.kp    <= cfg_data;
        REG_KI_VOLT:    cfg.volt.ki    <= cfg_data;
        REG_KD_VOLT:    cfg.volt.kd    <= cfg_data;
        REG_KP_CURR:    cfg.curr.kp    <= cfg_data;
        REG_KI_CURR:    cfg.curr.ki    <= cfg_data;
        REG_KD_CURR:    cfg.curr.kd    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/cvcc_pid_calc.sv
// three-term pid datapath with saturating integrator and drive clamp
module cvcc_pid_calc
  import cvcc_pkg::*;
(
  input  logic signed [ERR_W-1:0]   err,
  input  logic signed [ERR_W-1:0]   prev_err,
  input  logic signed [INTEG_W-1:0] integ,
  input  logic                      integ_en,
  input  gains_t                    gains,
  output logic signed [INTEG_W-1:0] integ_next,
  output logic [DRIVE_W-1:0]        drive_next
);

  localparam logic signed [SUM_W-1:0] SUM_CLAMP =
    SUM_W'(longint'(DRIVE_MAX) * longint'(2 ** FRAC_W));
  localparam logic signed [INTEG_W-1:0] INTEG_POS = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_NEG = {1'b1, {(INTEG_W-1){1'b0}}};

  logic signed [INTEG_W:0]   integ_add;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [P_W-1:0]     p_term;
  logic signed [I_W-1:0]     i_term;
  logic signed [D_W-1:0]     d_term;
  logic signed [SUM_W-1:0]   sum;

  assign integ_add = (INTEG_W+1)'(integ) + (INTEG_W+1)'(err);

  always_comb begin
    if (integ_add[INTEG_W] != integ_add[INTEG_W-1]) begin
      integ_sat = integ_add[INTEG_W] ? INTEG_NEG : INTEG_POS;
    end else begin
      integ_sat = integ_add[INTEG_W-1:0];
    end
  end

  assign integ_next = integ_en ? integ_sat : integ;
  assign diff       = DIFF_W'(err) - DIFF_W'(prev_err);

  assign p_term = $signed({1'b0, gains.kp}) * err;
  assign i_term = $signed({1'b0, gains.ki}) * integ_next;
  assign d_term = $signed({1'b0, gains.kd}) * diff;
  assign sum    = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);

  always_comb begin
    if (sum >= SUM_CLAMP) begin
      drive_next = DRIVE_W'(DRIVE_MAX);
    end else if (sum[SUM_W-1] || sum == '0) begin
      drive_next = DRIVE_W'(1);
    end else begin
      drive_next = sum[FRAC_W +: DRIVE_W];
    end
  end

endmodule
